>>> rtl/pfcs_pkg.sv
// Shared types and constants for the parallel flash command sequencer.
package pfcs_pkg;

    localparam int BUS_ADDR_W  = 19;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int STEP_W      = 3;

    typedef logic [BUS_ADDR_W-1:0] bus_addr_t;

    // Operation codes of a command transaction
    localparam logic [2:0] OP_PROGRAM      = 3'd0;
    localparam logic [2:0] OP_ERASE_SECTOR = 3'd1;
    localparam logic [2:0] OP_ERASE_CHIP   = 3'd2;
    localparam logic [2:0] OP_READ_ID      = 3'd3;
    localparam logic [2:0] OP_READ_RESP    = 3'd4;

    // Finish status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TIMEOUT    = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;

    // JEDEC command set
    localparam bus_addr_t  ADDR_UNLOCK1   = 19'h05555;
    localparam bus_addr_t  ADDR_UNLOCK2   = 19'h02AAA;
    localparam bus_addr_t  ADDR_ID_MANUF  = 19'h00000;
    localparam bus_addr_t  ADDR_ID_DEVICE = 19'h00001;
    localparam logic [7:0] DATA_UNLOCK1   = 8'hAA;
    localparam logic [7:0] DATA_UNLOCK2   = 8'h55;
    localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
    localparam logic [7:0] CMD_ERASE      = 8'h80;
    localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
    localparam logic [7:0] CMD_SECT_ERASE = 8'h30;
    localparam logic [7:0] CMD_ID_ENTRY   = 8'h90;
    localparam logic [7:0] CMD_ID_EXIT    = 8'hF0;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'hF000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PROG_POLL,
        PH_ERASE_POLL,
        PH_ID_FIRST,
        PH_ID_SECOND
    } phase_t;

    typedef enum logic [1:0] {
        CK_WRITE,
        CK_READ,
        CK_FINISH
    } cycle_kind_t;

    // Bus sequences the back end knows how to play out
    typedef enum logic [2:0] {
        SEQ_PROGRAM,
        SEQ_ERASE_SECTOR,
        SEQ_ERASE_CHIP,
        SEQ_ID_ENTER,
        SEQ_READ,
        SEQ_FINISH,
        SEQ_ID_EXIT
    } seq_kind_t;

    typedef struct packed {
        seq_kind_t   kind;
        bus_addr_t   addr;
        logic [7:0]  data;
        logic [15:0] value;
        logic [1:0]  status;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> rtl/pfcs_front.sv
// Front end: takes command and read-response transactions, tracks phase, issues descriptors.
module pfcs_front #(
    parameter int ADDR_BITS = 19
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [15:0]              cfg_wr_data,
    input  logic                     accept,
    input  logic [2:0]               operation,
    input  logic [18:0]              address,
    input  logic [7:0]               prog_byte,
    input  logic                     burst_end,
    input  logic [7:0]               read_data,
    output pfcs_pkg::desc_t          desc
);

    pfcs_pkg::phase_t       phase_reg, phase_next;
    logic [ADDR_BITS-1:0]   target_reg, target_next;
    logic [7:0]             expected_reg, expected_next;
    logic [15:0]            poll_reg, poll_next;
    logic [7:0]             first_id_reg, first_id_next;
    logic                   burst_open_reg, burst_open_next;
    logic [15:0]            poll_limit_reg;

    logic                   unexpected;
    logic [ADDR_BITS-1:0]   addr_in;
    logic [ADDR_BITS-1:0]   prog_target;
    logic                   poll_done;
    logic                   poll_expired;

    assign addr_in     = ADDR_BITS'(address);
    assign prog_target = burst_open_reg ? target_reg : addr_in;
    assign unexpected  = (operation > pfcs_pkg::OP_READ_RESP)
                      || ((operation < pfcs_pkg::OP_READ_RESP)
                          && (phase_reg != pfcs_pkg::PH_IDLE))
                      || ((operation == pfcs_pkg::OP_READ_RESP)
                          && (phase_reg == pfcs_pkg::PH_IDLE));
    assign poll_done    = (phase_reg == pfcs_pkg::PH_PROG_POLL) ? (read_data == expected_reg)
                                                                : read_data[7];
    assign poll_expired = (poll_reg >= poll_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pfcs_pkg::PH_IDLE;
            target_reg     <= '0;
            expected_reg   <= '0;
            poll_reg       <= '0;
            first_id_reg   <= '0;
            burst_open_reg <= 1'b0;
            poll_limit_reg <= pfcs_pkg::POLL_LIMIT_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            expected_reg   <= expected_next;
            poll_reg       <= poll_next;
            first_id_reg   <= first_id_next;
            burst_open_reg <= burst_open_next;
            if (cfg_wr_en)
            begin
                poll_limit_reg <= cfg_wr_data;
            end
        end
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        target_next     = target_reg;
        expected_next   = expected_reg;
        poll_next       = poll_reg;
        first_id_next   = first_id_reg;
        burst_open_next = burst_open_reg;
        if (accept && !unexpected)
        begin
            case (operation)
                pfcs_pkg::OP_PROGRAM:
                begin
                    target_next     = prog_target;
                    expected_next   = prog_byte;
                    burst_open_next = !burst_end;
                    poll_next       = 16'd1;
                    phase_next      = pfcs_pkg::PH_PROG_POLL;
                end
                pfcs_pkg::OP_ERASE_SECTOR:
                begin
                    burst_open_next = 1'b0;
                    target_next     = addr_in;
                    poll_next       = 16'd1;
                    phase_next      = pfcs_pkg::PH_ERASE_POLL;
                end
                pfcs_pkg::OP_ERASE_CHIP:
                begin
                    burst_open_next = 1'b0;
                    target_next     = '0;
                    poll_next       = 16'd1;
                    phase_next      = pfcs_pkg::PH_ERASE_POLL;
                end
                pfcs_pkg::OP_READ_ID:
                begin
                    burst_open_next = 1'b0;
                    phase_next      = pfcs_pkg::PH_ID_FIRST;
                end
                default:
                begin
                    case (phase_reg)
                        pfcs_pkg::PH_PROG_POLL, pfcs_pkg::PH_ERASE_POLL:
                        begin
                            if (poll_done)
                            begin
                                if (phase_reg == pfcs_pkg::PH_PROG_POLL)
                                begin
                                    target_next = target_reg + 1'b1;
                                end
                                phase_next = pfcs_pkg::PH_IDLE;
                            end
                            else if (poll_expired)
                            begin
                                burst_open_next = 1'b0;
                                phase_next      = pfcs_pkg::PH_IDLE;
                            end
                            else
                            begin
                                poll_next = poll_reg + 16'd1;
                            end
                        end
                        pfcs_pkg::PH_ID_FIRST:
                        begin
                            first_id_next = read_data;
                            phase_next    = pfcs_pkg::PH_ID_SECOND;
                        end
                        pfcs_pkg::PH_ID_SECOND:
                        begin
                            phase_next = pfcs_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            endcase
        end
    end

    // Descriptor for the back end
    always_comb
    begin
        desc        = '0;
        desc.kind   = pfcs_pkg::SEQ_FINISH;
        desc.status = pfcs_pkg::ST_UNEXPECTED;
        if (!unexpected)
        begin
            case (operation)
                pfcs_pkg::OP_PROGRAM:
                begin
                    desc.kind   = pfcs_pkg::SEQ_PROGRAM;
                    desc.addr   = pfcs_pkg::bus_addr_t'(prog_target);
                    desc.data   = prog_byte;
                    desc.status = pfcs_pkg::ST_OK;
                end
                pfcs_pkg::OP_ERASE_SECTOR:
                begin
                    desc.kind   = pfcs_pkg::SEQ_ERASE_SECTOR;
                    desc.addr   = pfcs_pkg::bus_addr_t'(addr_in);
                    desc.status = pfcs_pkg::ST_OK;
                end
                pfcs_pkg::OP_ERASE_CHIP:
                begin
                    desc.kind   = pfcs_pkg::SEQ_ERASE_CHIP;
                    desc.status = pfcs_pkg::ST_OK;
                end
                pfcs_pkg::OP_READ_ID:
                begin
                    desc.kind   = pfcs_pkg::SEQ_ID_ENTER;
                    desc.status = pfcs_pkg::ST_OK;
                end
                default:
                begin
                    case (phase_reg)
                        pfcs_pkg::PH_PROG_POLL, pfcs_pkg::PH_ERASE_POLL:
                        begin
                            if (poll_done || poll_expired)
                            begin
                                desc.kind   = pfcs_pkg::SEQ_FINISH;
                                desc.value  = poll_reg;
                                desc.status = poll_done ? pfcs_pkg::ST_OK
                                                        : pfcs_pkg::ST_TIMEOUT;
                            end
                            else
                            begin
                                desc.kind   = pfcs_pkg::SEQ_READ;
                                desc.addr   = pfcs_pkg::bus_addr_t'(target_reg);
                                desc.status = pfcs_pkg::ST_OK;
                            end
                        end
                        pfcs_pkg::PH_ID_FIRST:
                        begin
                            desc.kind   = pfcs_pkg::SEQ_READ;
                            desc.addr   = pfcs_pkg::ADDR_ID_DEVICE;
                            desc.status = pfcs_pkg::ST_OK;
                        end
                        pfcs_pkg::PH_ID_SECOND:
                        begin
                            desc.kind   = pfcs_pkg::SEQ_ID_EXIT;
                            desc.value  = {first_id_reg, read_data};
                            desc.status = pfcs_pkg::ST_OK;
                        end
                        default:
                        begin
                            desc.kind   = pfcs_pkg::SEQ_FINISH;
                            desc.status = pfcs_pkg::ST_UNEXPECTED;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

>>> rtl/pfcs_queue.sv
// Short descriptor queue between front and back end.
module pfcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pfcs_pkg::desc_t     push_desc,
    input  logic                pop,
    output pfcs_pkg::desc_t     head,
    output pfcs_pkg::q_stat_t   stat
);

    pfcs_pkg::desc_t                 entry_reg [pfcs_pkg::QUEUE_DEPTH];
    logic [pfcs_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [pfcs_pkg::QPTR_W:0]       count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (pfcs_pkg::QPTR_W+1)'(pfcs_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/pfcs_back.sv
// Back end: expands each descriptor into bus cycle and finish results, one per clock while out_ready allows.
module pfcs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfcs_pkg::desc_t         head,
    input  pfcs_pkg::q_stat_t       q_stat,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pfcs_pkg::cycle_kind_t   out_kind,
    output pfcs_pkg::bus_addr_t     out_addr,
    output logic [7:0]              out_data,
    output logic                    out_last,
    output logic [15:0]             out_value,
    output logic [1:0]              out_status
);

    logic [pfcs_pkg::STEP_W-1:0] step_reg;
    logic                        valid_reg;
    pfcs_pkg::cycle_kind_t       kind_reg;
    pfcs_pkg::bus_addr_t         addr_reg;
    logic [7:0]                  data_reg;
    logic                        last_reg;
    logic [15:0]                 value_reg;
    logic [1:0]                  status_reg;

    pfcs_pkg::cycle_kind_t       it_kind;
    pfcs_pkg::bus_addr_t         it_addr;
    logic [7:0]                  it_data;
    logic                        it_last;
    logic [15:0]                 it_value;
    logic [1:0]                  it_status;
    logic                        load;

    assign load = !q_stat.empty && (!valid_reg || out_ready);
    assign pop  = load && it_last;

    // Item at the current step of the head sequence
    always_comb
    begin
        it_kind   = pfcs_pkg::CK_WRITE;
        it_addr   = '0;
        it_data   = '0;
        it_last   = 1'b0;
        it_value  = '0;
        it_status = pfcs_pkg::ST_OK;
        case (head.kind)
            pfcs_pkg::SEQ_READ:
            begin
                it_kind = pfcs_pkg::CK_READ;
                it_addr = head.addr;
                it_last = 1'b1;
            end
            pfcs_pkg::SEQ_FINISH:
            begin
                it_kind   = pfcs_pkg::CK_FINISH;
                it_value  = head.value;
                it_status = head.status;
                it_last   = 1'b1;
            end
            default:
            begin
                // every longer sequence opens with the two unlock writes
                case (step_reg)
                    3'd0, 3'd3:
                    begin
                        it_addr = pfcs_pkg::ADDR_UNLOCK1;
                        it_data = pfcs_pkg::DATA_UNLOCK1;
                    end
                    3'd1, 3'd4:
                    begin
                        it_addr = pfcs_pkg::ADDR_UNLOCK2;
                        it_data = pfcs_pkg::DATA_UNLOCK2;
                    end
                    default:
                    begin
                        it_addr = '0;
                    end
                endcase
                case (head.kind)
                    pfcs_pkg::SEQ_PROGRAM:
                    begin
                        case (step_reg)
                            3'd2:
                            begin
                                it_addr = pfcs_pkg::ADDR_UNLOCK1;
                                it_data = pfcs_pkg::CMD_PROGRAM;
                            end
                            3'd3:
                            begin
                                it_addr = head.addr;
                                it_data = head.data;
                            end
                            3'd4:
                            begin
                                it_kind = pfcs_pkg::CK_READ;
                                it_addr = head.addr;
                                it_data = '0;
                                it_last = 1'b1;
                            end
                            default:
                            begin
                                it_last = 1'b0;
                            end
                        endcase
                    end
                    pfcs_pkg::SEQ_ERASE_SECTOR, pfcs_pkg::SEQ_ERASE_CHIP:
                    begin
                        case (step_reg)
                            3'd2:
                            begin
                                it_addr = pfcs_pkg::ADDR_UNLOCK1;
                                it_data = pfcs_pkg::CMD_ERASE;
                            end
                            3'd5:
                            begin
                                if (head.kind == pfcs_pkg::SEQ_ERASE_SECTOR)
                                begin
                                    it_addr = head.addr;
                                    it_data = pfcs_pkg::CMD_SECT_ERASE;
                                end
                                else
                                begin
                                    it_addr = pfcs_pkg::ADDR_UNLOCK1;
                                    it_data = pfcs_pkg::CMD_CHIP_ERASE;
                                end
                            end
                            3'd6:
                            begin
                                it_kind = pfcs_pkg::CK_READ;
                                it_addr = head.addr;
                                it_last = 1'b1;
                            end
                            default:
                            begin
                                it_last = 1'b0;
                            end
                        endcase
                    end
                    pfcs_pkg::SEQ_ID_ENTER, pfcs_pkg::SEQ_ID_EXIT:
                    begin
                        case (step_reg)
                            3'd2:
                            begin
                                it_addr = pfcs_pkg::ADDR_UNLOCK1;
                                it_data = (head.kind == pfcs_pkg::SEQ_ID_ENTER)
                                        ? pfcs_pkg::CMD_ID_ENTRY : pfcs_pkg::CMD_ID_EXIT;
                            end
                            3'd3:
                            begin
                                it_data = '0;
                                it_last = 1'b1;
                                if (head.kind == pfcs_pkg::SEQ_ID_ENTER)
                                begin
                                    it_kind = pfcs_pkg::CK_READ;
                                    it_addr = pfcs_pkg::ADDR_ID_MANUF;
                                end
                                else
                                begin
                                    it_kind   = pfcs_pkg::CK_FINISH;
                                    it_addr   = '0;
                                    it_value  = head.value;
                                    it_status = pfcs_pkg::ST_OK;
                                end
                            end
                            default:
                            begin
                                it_last = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        it_last = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= it_last ? '0 : step_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= it_kind;
            addr_reg   <= it_addr;
            data_reg   <= it_data;
            last_reg   <= it_last;
            value_reg  <= it_value;
            status_reg <= it_status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_addr   = addr_reg;
    assign out_data   = data_reg;
    assign out_last   = last_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;

endmodule

>>> rtl/parallel_flash_command_sequencer_top.sv
// Top level of the parallel NOR flash command sequencer.
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser operation, tlast burst_end, tdata fields
//  m_*       out        m_tvalid/m_tready   tuser cycle_kind, tlast last, tdata fields
//  cfg_*     in         cfg_wr_en           poll limit, 16 bits
//
// Rates: the front end takes one transaction per clock while the four-entry
// descriptor queue has room; the back end plays out one result per clock while
// m_tready is up, and a transaction expands into 1 to 7 results.
// That single result emitter sets the sustained rate.
// Reset clears phase, counters, queue and output valid at once; no sweep.
// A stall on m_tready holds the output register; the queue keeps s_tready up
// until four descriptors are waiting.
module parallel_flash_command_sequencer_top #(
    parameter int ADDR_BITS = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[18:0], prog_byte[26:19], read_data[34:27], zero
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        s_tlast,   // burst_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bus_address[18:0], bus_data[26:19],
                                   // result_value[42:27], status[44:43], zero
    output logic [1:0]  m_tuser,   // cycle_kind[1:0]
    output logic        m_tlast    // last
);

    pfcs_pkg::desc_t       front_desc;
    pfcs_pkg::desc_t       head_desc;
    pfcs_pkg::q_stat_t     q_stat;
    logic                  accept;
    logic                  pop;
    pfcs_pkg::cycle_kind_t out_kind;
    pfcs_pkg::bus_addr_t   out_addr;
    logic [7:0]            out_data;
    logic [15:0]           out_value;
    logic [1:0]            out_status;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    pfcs_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .operation   (s_tuser),
        .address     (s_tdata[18:0]),
        .prog_byte   (s_tdata[26:19]),
        .burst_end   (s_tlast),
        .read_data   (s_tdata[34:27]),
        .desc        (front_desc)
    );

    pfcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_desc (front_desc),
        .pop       (pop),
        .head      (head_desc),
        .stat      (q_stat)
    );

    pfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_desc),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_addr   (out_addr),
        .out_data   (out_data),
        .out_last   (m_tlast),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {3'b000, out_status, out_value, out_data, out_addr};

    // A finish always closes the results of its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == pfcs_pkg::CK_FINISH)) |-> m_tlast)
        else $error("finish result without last");

    // Bus cycles carry neither value nor status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != pfcs_pkg::CK_FINISH))
            |-> ((m_tdata[42:27] == 16'd0) && (m_tdata[44:43] == pfcs_pkg::ST_OK)))
        else $error("bus cycle with finish fields set");

    // Reads and finishes drive no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != pfcs_pkg::CK_WRITE)) |-> (m_tdata[26:19] == 8'd0))
        else $error("non-write result with bus data");

    // Queue cannot report full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

endmodule

>>> dv/parallel_flash_command_sequencer_top_tb.sv
// Self-checking bench for the parallel flash sequencer: command and poll-response streams against a shadow model.
`timescale 1ns / 100ps

module parallel_flash_command_sequencer_top_tb;

    // Operation codes the block must reject
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam int SETTLE_CYCLES = 4;       // quiet cycles before a register write
    localparam int DRAIN_CYCLES  = 24;      // tail after the last due result
    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int SEGMENTS      = 6;
    localparam int SEG_XACTS     = 56;

    typedef enum logic [1:0] {
        IT_XACT,    // command or read-response transaction
        IT_CFG,     // poll limit write, only once the block is quiet
        IT_DRAIN,   // hold the sender until every due result is back
        IT_PACE     // change the stall rates of both sides
    } item_kind_t;

    typedef struct {
        item_kind_t          kind;
        logic [2:0]          op;
        pfcs_pkg::bus_addr_t addr;
        logic [7:0]          wdata;
        logic                bend;
        logic [7:0]          rdata;
        logic [15:0]         value;
        int                  tx_pct;
        int                  rx_pct;
    } flash_request_t;

    typedef struct {
        pfcs_pkg::cycle_kind_t kind;
        pfcs_pkg::bus_addr_t   addr;
        logic [7:0]            data;
        logic                  last;
        logic [15:0]           value;
        logic [1:0]            status;
    } bus_cycle_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // address[18:0], prog_byte[26:19], read_data[34:27], zero
    logic [2:0]  s_tuser = '0;      // operation[2:0]
    logic        s_tlast = 1'b0;    // burst_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // bus_address[18:0], bus_data[26:19],
                                    // result_value[42:27], status[44:43], zero
    logic [1:0]  m_tuser;           // cycle_kind[1:0]
    logic        m_tlast;           // last

    // Stimulus still to go, and bus cycles predicted but not yet seen
    flash_request_t flash_requests[$];
    bus_cycle_t     due_cycles[$];
    bus_cycle_t     staged[$];
    flash_request_t in_flight;

    // Shadow of the sequencer state
    pfcs_pkg::phase_t    seq_phase = pfcs_pkg::PH_IDLE;
    pfcs_pkg::bus_addr_t tgt_addr = '0;
    logic [7:0]          want_byte = '0;
    logic [15:0]         polls_issued = '0;
    logic [7:0]          manuf_id = '0;
    logic                burst_live = 1'b0;
    logic [15:0]         poll_limit_shadow = pfcs_pkg::POLL_LIMIT_RESET;

    int idle_tx_pct = 38;
    int idle_rx_pct = 59;
    int quiet_cycles = 0;
    int xacts_queued = 0;
    int xacts_sent = 0;
    int cycles_checked = 0;
    int timeouts_seen = 0;
    int rejects_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    logic [15:0] odd_limit;

    parallel_flash_command_sequencer_top #(
        .ADDR_BITS (19)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow model: bus cycles and finishes that one transaction causes
    // ------------------------------------------------------------------
    task automatic stage(input pfcs_pkg::cycle_kind_t kind, input pfcs_pkg::bus_addr_t addr,
                         input logic [7:0] data, input logic [15:0] value,
                         input logic [1:0] status);
        bus_cycle_t c;
        c.kind   = kind;
        c.addr   = addr;
        c.data   = data;
        c.last   = 1'b0;
        c.value  = value;
        c.status = status;
        staged.push_back(c);
    endtask

    task automatic stage_unlock();
        stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1, pfcs_pkg::DATA_UNLOCK1, '0,
              pfcs_pkg::ST_OK);
        stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK2, pfcs_pkg::DATA_UNLOCK2, '0,
              pfcs_pkg::ST_OK);
    endtask

    task automatic plan_bus_cycles(input flash_request_t t);
        logic polled_ok;
        staged.delete();
        if (t.op > pfcs_pkg::OP_READ_RESP ||
            (t.op != pfcs_pkg::OP_READ_RESP && seq_phase != pfcs_pkg::PH_IDLE) ||
            (t.op == pfcs_pkg::OP_READ_RESP && seq_phase == pfcs_pkg::PH_IDLE))
        begin
            // wrong phase or unknown code: reject, state untouched
            stage(pfcs_pkg::CK_FINISH, '0, '0, '0, pfcs_pkg::ST_UNEXPECTED);
        end
        else
        begin
            case (t.op)
                pfcs_pkg::OP_PROGRAM:
                begin
                    // an open burst carries on at the next address
                    if (!burst_live)
                        tgt_addr = t.addr;
                    want_byte  = t.wdata;
                    burst_live = !t.bend;
                    stage_unlock();
                    stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1, pfcs_pkg::CMD_PROGRAM,
                          '0, pfcs_pkg::ST_OK);
                    stage(pfcs_pkg::CK_WRITE, tgt_addr, want_byte, '0, pfcs_pkg::ST_OK);
                    stage(pfcs_pkg::CK_READ, tgt_addr, '0, '0, pfcs_pkg::ST_OK);
                    polls_issued = 16'd1;
                    seq_phase    = pfcs_pkg::PH_PROG_POLL;
                end
                pfcs_pkg::OP_ERASE_SECTOR, pfcs_pkg::OP_ERASE_CHIP:
                begin
                    burst_live = 1'b0;
                    tgt_addr   = (t.op == pfcs_pkg::OP_ERASE_SECTOR) ? t.addr : '0;
                    stage_unlock();
                    stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1, pfcs_pkg::CMD_ERASE,
                          '0, pfcs_pkg::ST_OK);
                    stage_unlock();
                    if (t.op == pfcs_pkg::OP_ERASE_SECTOR)
                        stage(pfcs_pkg::CK_WRITE, tgt_addr, pfcs_pkg::CMD_SECT_ERASE, '0,
                              pfcs_pkg::ST_OK);
                    else
                        stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1,
                              pfcs_pkg::CMD_CHIP_ERASE, '0, pfcs_pkg::ST_OK);
                    stage(pfcs_pkg::CK_READ, tgt_addr, '0, '0, pfcs_pkg::ST_OK);
                    polls_issued = 16'd1;
                    seq_phase    = pfcs_pkg::PH_ERASE_POLL;
                end
                pfcs_pkg::OP_READ_ID:
                begin
                    burst_live = 1'b0;
                    stage_unlock();
                    stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1, pfcs_pkg::CMD_ID_ENTRY,
                          '0, pfcs_pkg::ST_OK);
                    stage(pfcs_pkg::CK_READ, pfcs_pkg::ADDR_ID_MANUF, '0, '0, pfcs_pkg::ST_OK);
                    seq_phase = pfcs_pkg::PH_ID_FIRST;
                end
                default:
                begin
                    if (seq_phase == pfcs_pkg::PH_PROG_POLL ||
                        seq_phase == pfcs_pkg::PH_ERASE_POLL)
                    begin
                        // program: data matches; erase: DQ7 set
                        polled_ok = (seq_phase == pfcs_pkg::PH_PROG_POLL)
                                  ? (t.rdata == want_byte) : t.rdata[7];
                        if (polled_ok)
                        begin
                            stage(pfcs_pkg::CK_FINISH, '0, '0, polls_issued, pfcs_pkg::ST_OK);
                            if (seq_phase == pfcs_pkg::PH_PROG_POLL)
                                tgt_addr = tgt_addr + 1'b1;
                            seq_phase = pfcs_pkg::PH_IDLE;
                        end
                        else if (polls_issued >= poll_limit_shadow)
                        begin
                            stage(pfcs_pkg::CK_FINISH, '0, '0, polls_issued,
                                  pfcs_pkg::ST_TIMEOUT);
                            burst_live = 1'b0;
                            seq_phase  = pfcs_pkg::PH_IDLE;
                        end
                        else
                        begin
                            polls_issued = polls_issued + 1'b1;
                            stage(pfcs_pkg::CK_READ, tgt_addr, '0, '0, pfcs_pkg::ST_OK);
                        end
                    end
                    else if (seq_phase == pfcs_pkg::PH_ID_FIRST)
                    begin
                        manuf_id = t.rdata;
                        stage(pfcs_pkg::CK_READ, pfcs_pkg::ADDR_ID_DEVICE, '0, '0,
                              pfcs_pkg::ST_OK);
                        seq_phase = pfcs_pkg::PH_ID_SECOND;
                    end
                    else
                    begin
                        // second id byte: leave id mode, then report both
                        stage_unlock();
                        stage(pfcs_pkg::CK_WRITE, pfcs_pkg::ADDR_UNLOCK1, pfcs_pkg::CMD_ID_EXIT,
                              '0, pfcs_pkg::ST_OK);
                        stage(pfcs_pkg::CK_FINISH, '0, '0, {manuf_id, t.rdata},
                              pfcs_pkg::ST_OK);
                        seq_phase = pfcs_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        staged[staged.size() - 1].last = 1'b1;
        while (staged.size() != 0)
            due_cycles.push_back(staged.pop_front());
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic pfcs_pkg::bus_addr_t rand_addr();
        // bias towards the top of the space so burst wrap is hit
        if ($urandom_range(0, 7) == 0)
            return pfcs_pkg::bus_addr_t'('1) - pfcs_pkg::bus_addr_t'($urandom_range(0, 2));
        return pfcs_pkg::bus_addr_t'($urandom);
    endfunction

    task automatic queue_xact(input logic [2:0] op, input pfcs_pkg::bus_addr_t addr,
                              input logic [7:0] wdata, input logic bend,
                              input logic [7:0] rdata);
        flash_request_t r;
        r.kind  = IT_XACT;
        r.op    = op;
        r.addr  = addr;
        r.wdata = wdata;
        r.bend  = bend;
        r.rdata = rdata;
        flash_requests.push_back(r);
        xacts_queued++;
    endtask

    task automatic queue_ctrl(input item_kind_t kind, input logic [15:0] value,
                              input int tx_pct, input int rx_pct);
        flash_request_t r;
        r.kind   = kind;
        r.value  = value;
        r.tx_pct = tx_pct;
        r.rx_pct = rx_pct;
        flash_requests.push_back(r);
    endtask

    task automatic queue_response(input logic [7:0] rdata);
        queue_xact(pfcs_pkg::OP_READ_RESP, rand_addr(), 8'($urandom), 1'($urandom), rdata);
    endtask

    task automatic queue_stray_command();
        queue_xact(3'($urandom_range(0, 3)), rand_addr(), 8'($urandom), 1'($urandom),
                   8'($urandom));
    endtask

    // Failing polls then the one that succeeds; a stray command may land between
    task automatic queue_poll_tail(input logic for_program, input logic [7:0] wbyte,
                                   input logic stray);
        int fails;
        int stray_at;
        int k;
        logic [7:0] rd;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: fails = $urandom_range(0, 2);
            6, 7, 8:          fails = $urandom_range(3, 5);
            default:          fails = $urandom_range(6, 10);
        endcase
        stray_at = stray ? $urandom_range(0, fails) : -1;
        for (k = 0; k <= fails; k++)
        begin
            if (k == stray_at)
                queue_stray_command();
            if (for_program)
            begin
                if (k == fails)
                    rd = wbyte;
                else
                begin
                    rd = 8'($urandom);
                    if (rd == wbyte)
                        rd = ~wbyte;
                end
            end
            else
                rd = (k < fails) ? (8'($urandom) & 8'h7F) : (8'($urandom) | 8'h80);
            queue_response(rd);
        end
    endtask

    task automatic queue_program_burst(input logic stray);
        int n;
        int i;
        pfcs_pkg::bus_addr_t base;
        logic [7:0] wb;
        logic leave_open;
        n          = $urandom_range(1, 4);
        base       = rand_addr();
        leave_open = ($urandom_range(0, 4) == 0);
        for (i = 0; i < n; i++)
        begin
            wb = 8'($urandom);
            queue_xact(pfcs_pkg::OP_PROGRAM, (i == 0) ? base : rand_addr(), wb,
                       (i == n - 1) && !leave_open, 8'($urandom));
            queue_poll_tail(1'b1, wb, stray && (i == 0));
        end
    endtask

    task automatic queue_erase(input logic [2:0] op, input logic stray);
        queue_xact(op, rand_addr(), 8'($urandom), 1'($urandom), 8'($urandom));
        queue_poll_tail(1'b0, 8'h00, stray);
    endtask

    task automatic queue_read_id(input logic stray);
        queue_xact(pfcs_pkg::OP_READ_ID, rand_addr(), 8'($urandom), 1'($urandom),
                   8'($urandom));
        if (stray)
            queue_stray_command();
        queue_response(8'($urandom));
        queue_response(8'($urandom));
    endtask

    task automatic queue_random_segment(input int goal);
        int pick;
        logic stray;
        while (xacts_queued < goal)
        begin
            pick  = $urandom_range(0, 99);
            stray = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 29) == 0)
                queue_ctrl(IT_DRAIN, '0, 0, 0);
            if (pick < 40)
                queue_program_burst(stray);
            else if (pick < 58)
                queue_erase(pfcs_pkg::OP_ERASE_SECTOR, stray);
            else if (pick < 68)
                queue_erase(pfcs_pkg::OP_ERASE_CHIP, stray);
            else if (pick < 85)
                queue_read_id(stray);
            else
                // stray response while idle, or a reserved code
                queue_xact(3'($urandom_range(4, 7)), rand_addr(), 8'($urandom),
                           1'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR result %0d: %s got 0x%0h, expected 0x%0h",
                 cycles_checked, field, got, want);
        error_count++;
    endtask

    task automatic check_cycle(input bus_cycle_t got, input bus_cycle_t want);
        if (got.kind != want.kind)
            report_mismatch("cycle_kind", got.kind, want.kind);
        if (got.addr != want.addr)
            report_mismatch("bus_address", got.addr, want.addr);
        if (got.data != want.data)
            report_mismatch("bus_data", got.data, want.data);
        if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        if (got.value != want.value)
            report_mismatch("result_value", got.value, want.value);
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
    endtask

    // ------------------------------------------------------------------
    // Driver: command/response transactions, register writes, pacing
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : cmd_driver
        logic           next_valid;
        logic           next_cfg_en;
        flash_request_t head;
        next_valid  = s_tvalid;
        next_cfg_en = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                plan_bus_cycles(in_flight);
                xacts_sent++;
                next_valid = 1'b0;
            end
            if (due_cycles.size() == 0 && !next_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!next_valid && flash_requests.size() != 0)
            begin
                head = flash_requests[0];
                case (head.kind)
                    IT_XACT:
                    begin
                        if ($urandom_range(0, 99) >= idle_tx_pct)
                        begin
                            in_flight = head;
                            void'(flash_requests.pop_front());
                            next_valid = 1'b1;
                            s_tdata <= {5'd0, head.rdata, head.wdata, head.addr};
                            s_tuser <= head.op;
                            s_tlast <= head.bend;
                        end
                    end
                    IT_CFG:
                    begin
                        // only with nothing in flight and nothing due
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            next_cfg_en = 1'b1;
                            cfg_wr_data <= head.value;
                            poll_limit_shadow = head.value;
                            quiet_cycles = 0;
                            void'(flash_requests.pop_front());
                        end
                    end
                    IT_DRAIN:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                            void'(flash_requests.pop_front());
                    end
                    default:
                    begin
                        idle_tx_pct <= head.tx_pct;
                        idle_rx_pct <= head.rx_pct;
                        void'(flash_requests.pop_front());
                    end
                endcase
            end
        end
        s_tvalid  <= next_valid;
        cfg_wr_en <= next_cfg_en;
    end

    // ------------------------------------------------------------------
    // Monitor: every bus cycle and finish against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : cycle_monitor
        bus_cycle_t got;
        bus_cycle_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind   = pfcs_pkg::cycle_kind_t'(m_tuser);
                got.addr   = m_tdata[18:0];
                got.data   = m_tdata[26:19];
                got.value  = m_tdata[42:27];
                got.status = m_tdata[44:43];
                got.last   = m_tlast;
                cycles_checked++;
                if (due_cycles.size() == 0)
                    report_mismatch("result with nothing due, tdata", m_tdata, 0);
                else
                begin
                    want = due_cycles.pop_front();
                    if (want.kind == pfcs_pkg::CK_FINISH &&
                        want.status == pfcs_pkg::ST_TIMEOUT)
                        timeouts_seen++;
                    if (want.kind == pfcs_pkg::CK_FINISH &&
                        want.status == pfcs_pkg::ST_UNEXPECTED)
                        rejects_seen++;
                    check_cycle(got, want);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= idle_rx_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d requests queued and %0d results due",
                     flash_requests.size(), due_cycles.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int seg;
        // Directed: rejects, burst wrap at the top, burst address ignored,
        // stray command mid-poll, chip erase, id read, burst closed by
        // another command, then a zero poll limit at the reset-value tail.
        queue_xact(pfcs_pkg::OP_READ_RESP, '1, '1, 1'b1, 8'hFF);
        queue_xact(OP_RSVD_LO, '0, '0, 1'b0, 8'h00);
        queue_xact(OP_RSVD_HI, '1, '1, 1'b1, 8'hFF);
        queue_xact(pfcs_pkg::OP_PROGRAM, '1, 8'h00, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_PROGRAM, 19'h12345, 8'hFF, 1'b1, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h7F);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'hFF);
        queue_xact(pfcs_pkg::OP_ERASE_SECTOR, '1, 8'hFF, 1'b1, 8'hFF);
        queue_xact(pfcs_pkg::OP_READ_ID, '0, '0, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h80);
        queue_xact(pfcs_pkg::OP_ERASE_CHIP, 19'h2AAAA, 8'h55, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'hFF);
        queue_xact(pfcs_pkg::OP_READ_ID, '0, '0, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'hBF);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'hB7);
        queue_xact(pfcs_pkg::OP_PROGRAM, 19'h40000, 8'hA5, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'hA5);
        queue_xact(pfcs_pkg::OP_ERASE_CHIP, '0, '0, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h80);
        queue_xact(pfcs_pkg::OP_PROGRAM, 19'h00100, 8'h5A, 1'b1, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h5A);
        queue_ctrl(IT_CFG, 16'd0, 0, 0);
        queue_xact(pfcs_pkg::OP_PROGRAM, 19'h3C3C3, 8'hC3, 1'b0, 8'h00);
        queue_xact(pfcs_pkg::OP_READ_RESP, '0, '0, 1'b0, 8'h3C);

        // Random: six segments, each with its own poll limit; heavier stalls on
        // the receiver side first, then the sender side, then none.
        odd_limit = 16'($urandom_range(4, 8));
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: queue_ctrl(IT_CFG, 16'd1, 0, 0);
                1: queue_ctrl(IT_CFG, 16'd3, 0, 0);
                2: queue_ctrl(IT_CFG, 16'hFFFF, 0, 0);
                3: queue_ctrl(IT_CFG, 16'd2, 0, 0);
                4: queue_ctrl(IT_CFG, odd_limit, 0, 0);
                default: queue_ctrl(IT_CFG, pfcs_pkg::POLL_LIMIT_RESET, 0, 0);
            endcase
            if (seg == 2)
                queue_ctrl(IT_PACE, '0, 59, 38);
            else if (seg == 4)
                queue_ctrl(IT_PACE, '0, 0, 0);
            queue_random_segment(xacts_queued + SEG_XACTS);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (flash_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (due_cycles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transactions, %0d bus cycles and finishes checked",
                 xacts_sent, cycles_checked);
        $display("(%0d timeouts, %0d rejects); poll limits 0, 1, 2, 3, %0d, %0d, 65535",
                 timeouts_seen, rejects_seen, odd_limit, pfcs_pkg::POLL_LIMIT_RESET);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
